[src/sssd_pkg.sv]
// Package for the seven-segment scan driver: item types, command and register codes,
// the font table and the shared sequencer state type.
// Depends on nothing; used by every module of the block.
`default_nettype none

package sssd_pkg;

   // Command codes carried in the command field of an input item.
   localparam logic [2:0] CMD_TEXT    = 3'd0;
   localparam logic [2:0] CMD_DOT     = 3'd1;
   localparam logic [2:0] CMD_ALL_ON  = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_REFRESH = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TICKS = 1'd1;

   // Frame geometry: eight select bits followed by eight segment bits.
   localparam int unsigned FRAME_W  = 16;
   localparam int unsigned SEL_W    = 4;
   localparam logic [SEL_W-1:0] BLANK_SELECT = 4'd8;

   // Glyphs for hexadecimal characters, bit 7 (the dot) clear.
   localparam logic [7:0] HEX_GLYPH [16] = '{
      8'h7E, 8'h48, 8'h3D, 8'h6D, 8'h4B, 8'h67, 8'h77, 8'h4C,
      8'h7F, 8'h6F, 8'h5F, 8'h73, 8'h31, 8'h79, 8'h37, 8'h17
   };

   // Single-segment bars for the control codes one to four; code zero is blank.
   localparam logic [7:0] BAR_GLYPH [5] = '{8'h00, 8'h01, 8'h40, 8'h20, 8'h10};

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] char0;
      logic [7:0] char1;
      logic [7:0] char2;
      logic [7:0] char3;
      logic [1:0] digit_index;
      logic       dot_on;
   } sssd_req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_word;
      logic [SEL_W-1:0]   select_index;
      logic               last;
   } sssd_rsp_type;

   // Control from the sequencer to the frame shifter.
   typedef struct packed {
      logic               start;
      logic [FRAME_W-1:0] word;
   } sssd_shift_ctrl_type;

   // Status from the frame shifter back to the sequencer.
   typedef struct packed {
      logic               done;
      logic [FRAME_W-1:0] word;
   } sssd_shift_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_SHIFT,
      ST_EMIT
   } sssd_state_type;

   // Font lookup: digits and upper-case hex letters, bars for codes one to four,
   // blank for everything else (lower case and codes above 127 included).
   function automatic logic [7:0] glyph_of(input logic [7:0] code);
      logic [7:0] g;
      g = 8'h00;
      if (code inside {[8'h30:8'h39]}) begin
         g = HEX_GLYPH[code[3:0]];
      end else if (code inside {[8'h41:8'h46]}) begin
         g = HEX_GLYPH[4'(code[3:0] + 4'd9)];
      end else if (code inside {[8'h00:8'h04]}) begin
         g = BAR_GLYPH[code[2:0]];
      end
      return g;
   endfunction

endpackage

`default_nettype wire

[src/sssd_frame_shifter.sv]
// Frame shifter: sends one 16-bit frame out a bit per clock, then waits the hold time.
// The shifted bits are collected again so the frame can be reported as an item.
// Depends on sssd_pkg.
`default_nettype none

module sssd_frame_shifter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sssd_pkg::sssd_shift_ctrl_type ctrl,
   input  wire logic [15:0]                 hold_ticks,
   output sssd_pkg::sssd_shift_stat_type    stat
);
   import sssd_pkg::*;

   logic [FRAME_W-1:0] src_ff, src_in;
   logic [FRAME_W-1:0] cap_ff, cap_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic [15:0]        hold_cnt_ff, hold_cnt_in;
   logic               run_ff, run_in;
   logic               hold_ff, hold_in;
   logic               done_ff, done_in;
   logic [15:0]        hold_end;

   assign hold_end = hold_ticks - 16'd1;

   // Shift, hold and completion sequencing.
   always_comb begin
      src_in      = src_ff;
      cap_in      = cap_ff;
      bit_cnt_in  = bit_cnt_ff;
      hold_cnt_in = hold_cnt_ff;
      run_in      = run_ff;
      hold_in     = hold_ff;
      done_in     = 1'b0;
      if (ctrl.start) begin
         src_in     = ctrl.word;
         bit_cnt_in = '0;
         run_in     = 1'b1;
      end else if (run_ff) begin
         // The least significant bit leaves first and lands at the top of the capture.
         cap_in     = {src_ff[0], cap_ff[FRAME_W-1:1]};
         src_in     = {1'b0, src_ff[FRAME_W-1:1]};
         bit_cnt_in = bit_cnt_ff + 4'd1;
         if (bit_cnt_ff == 4'(FRAME_W - 1)) begin
            run_in = 1'b0;
            if (hold_ticks == 16'd0) begin
               done_in = 1'b1;
            end else begin
               hold_in     = 1'b1;
               hold_cnt_in = '0;
            end
         end
      end else if (hold_ff) begin
         hold_cnt_in = hold_cnt_ff + 16'd1;
         if (hold_cnt_ff == hold_end) begin
            hold_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         hold_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         hold_ff <= hold_in;
         done_ff <= done_in;
      end
      src_ff      <= src_in;
      cap_ff      <= cap_in;
      bit_cnt_ff  <= bit_cnt_in;
      hold_cnt_ff <= hold_cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.word = cap_ff;

endmodule

`default_nettype wire

[src/seven_segment_scan_driver.sv]
// Top level of the seven-segment scan driver: command sequencer, segment store,
// configuration registers and the registered result channel.
// Depends on sssd_pkg and sssd_frame_shifter.
`default_nettype none

// The block keeps one segment byte per digit and takes one command per item; it takes
// no new item until the current one is finished. Set text, set dot, all on and clear
// walk the segment store one digit a cycle, with no result. A refresh with enable set
// gives DIGITS + 1 frames, the last a blank frame with select index 8 and last set.
// Each frame goes through the shared frame shifter one bit per clock: it is loaded,
// shifted out, held for the hold ticks, completed and handed over to the result
// register; while the result register is full and stalled, the hand-over waits.
module seven_segment_scan_driver #(
   parameter int DIGITS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire sssd_pkg::sssd_req_type             req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output sssd_pkg::sssd_rsp_type                  rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sssd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [15:0]                        csr_wdata
);
   import sssd_pkg::*;

   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [SEL_W-1:0] DIGIT_COUNT = SEL_W'(DIGITS);
   localparam logic [SEL_W-1:0] LAST_DIGIT  = SEL_W'(DIGITS - 1);

   sssd_state_type      state_ff, state_in;
   sssd_req_type        item_ff;
   logic [SEL_W-1:0]    cnt_ff, cnt_in;
   logic [7:0]          store_ff [DIGITS];
   logic                enable_ff;
   logic [15:0]         hold_ticks_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   sssd_rsp_type        rsp_data_ff;

   logic                req_fire;
   logic                emit_fire;
   logic                store_we;
   logic [7:0]          store_wdata;
   logic [IDX_W-1:0]    idx;
   logic [7:0]          cur_seg;
   logic [7:0]          char_sel;
   logic                in_range;
   logic [7:0]          select_bits;
   logic [SEL_W-1:0]    select_index;
   sssd_shift_ctrl_type shift_ctrl;
   sssd_shift_stat_type shift_stat;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign idx       = cnt_ff[IDX_W-1:0];
   assign in_range  = (cnt_ff < DIGIT_COUNT);
   assign cur_seg   = in_range ? store_ff[idx] : 8'h00;

   // Character of the digit being written; digits beyond the fourth have none.
   always_comb begin
      case (cnt_ff)
         4'd0:    char_sel = item_ff.char0;
         4'd1:    char_sel = item_ff.char1;
         4'd2:    char_sel = item_ff.char2;
         4'd3:    char_sel = item_ff.char3;
         default: char_sel = 8'h00;
      endcase
   end

   // Select field of the current frame; the blank frame selects nothing.
   always_comb begin
      if (in_range) begin
         select_bits  = 8'(8'd1 << cnt_ff[2:0]);
         select_index = cnt_ff;
      end else begin
         select_bits  = 8'h00;
         select_index = BLANK_SELECT;
      end
   end

   // Next state of the command sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.command inside {CMD_TEXT, CMD_DOT, CMD_ALL_ON, CMD_CLEAR}) begin
                  state_in = ST_UPDATE;
               end else if (req_data.command == CMD_REFRESH && enable_ff) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_UPDATE: begin
            if (cnt_ff == LAST_DIGIT) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD:  state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (shift_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = (cnt_ff == DIGIT_COUNT) ? ST_IDLE : ST_LOAD;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: store writes, shifter start and the digit counter.
   always_comb begin
      store_we         = 1'b0;
      store_wdata      = cur_seg;
      shift_ctrl.start = 1'b0;
      shift_ctrl.word  = {cur_seg, select_bits};
      cnt_in           = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
         end
         ST_UPDATE: begin
            store_we = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            case (item_ff.command)
               CMD_TEXT: begin
                  store_wdata = glyph_of(char_sel) & 8'h7F;
               end
               CMD_DOT: begin
                  if (cnt_ff == {2'b00, item_ff.digit_index}) begin
                     store_wdata = {item_ff.dot_on, cur_seg[6:0]};
                  end
               end
               CMD_ALL_ON: store_wdata = 8'hFF;
               CMD_CLEAR:  store_wdata = 8'h00;
               default:    store_wdata = cur_seg;
            endcase
         end
         ST_LOAD: begin
            shift_ctrl.start = 1'b1;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Result register: a taken result frees it, a new frame fills it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         enable_ff     <= 1'b1;
         hold_ticks_ff <= 16'd0;
         for (int i = 0; i < DIGITS; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ENABLE:     enable_ff     <= csr_wdata[0];
               REG_HOLD_TICKS: hold_ticks_ff <= csr_wdata;
               default:        enable_ff     <= enable_ff;
            endcase
         end
         if (store_we) begin
            store_ff[idx] <= store_wdata;
         end
      end
      cnt_ff <= cnt_in;
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (emit_fire) begin
         rsp_data_ff.frame_word   <= shift_stat.word;
         rsp_data_ff.select_index <= select_index;
         rsp_data_ff.last         <= (cnt_ff == DIGIT_COUNT);
      end
   end

   sssd_frame_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (shift_ctrl),
      .hold_ticks (hold_ticks_ff),
      .stat       (shift_stat)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
